// File: rtl/gmc_pkg.sv
// ----------------------------------------------------------------------------
// gmc_pkg
// Shared types, codes and the direction order table of the maze carver.
// ----------------------------------------------------------------------------
package gmc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IDX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IDX = 2'd1;

    localparam logic [6:0] WIDTH_RESET  = 7'd40;
    localparam logic [5:0] HEIGHT_RESET = 6'd30;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] DIR_EAST  = 2'd0;
    localparam logic [1:0] DIR_WEST  = 2'd1;
    localparam logic [1:0] DIR_SOUTH = 2'd2;
    localparam logic [1:0] DIR_NORTH = 2'd3;

    typedef struct packed {
        logic [6:0] width_in_use;
        logic [5:0] height_in_use;
    } gmc_cfg_t;

    typedef struct packed {
        logic [5:0] popped_col;
        logic [4:0] popped_row;
        logic [3:0] carved_mask;
        logic       wall_bit;
        logic       stack_empty;
        logic       step_ignored;
    } gmc_result_t;

    // Lexicographic orders of east, west, south, north; first direction in [7:6].
    localparam logic [7:0] ORDER_TABLE [24] = '{
        8'h1B, 8'h1E, 8'h27, 8'h2D, 8'h36, 8'h39,
        8'h4B, 8'h4E, 8'h63, 8'h6C, 8'h72, 8'h78,
        8'h87, 8'h8D, 8'h93, 8'h9C, 8'hB1, 8'hB4,
        8'hC6, 8'hC9, 8'hD2, 8'hD8, 8'hE1, 8'hE4
    };

    function automatic logic [7:0] order_lookup(input logic [4:0] idx);
        logic [4:0] k;
        k = (idx >= 5'd24) ? (idx - 5'd24) : idx;
        return ORDER_TABLE[k];
    endfunction

endpackage

// File: rtl/gmc_ram.sv
// ----------------------------------------------------------------------------
// gmc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/gmc_engine.sv
// ----------------------------------------------------------------------------
// gmc_engine
// Sequencer around the grid row memory and the cell stack memory.
// ----------------------------------------------------------------------------
module gmc_engine #(
    parameter int GRID_COLS   = 64,
    parameter int GRID_ROWS   = 32,
    parameter int STACK_DEPTH = 512
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gmc_pkg::gmc_cfg_t    cfg,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic [5:0]           cell_col,
    input  logic [4:0]           cell_row,
    input  logic [4:0]           order_index,
    output logic                 res_valid,
    input  logic                 res_take,
    output gmc_pkg::gmc_result_t res
);

    localparam int CW  = $clog2(GRID_COLS);
    localparam int RW  = $clog2(GRID_ROWS);
    localparam int CX  = CW + 1;
    localparam int RX  = RW + 1;
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam int EW  = CW + RW;
    localparam int CBW = $clog2(GRID_COLS + 1);
    localparam int RBW = $clog2(GRID_ROWS + 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_DIR,
        S_CHECK,
        S_MID,
        S_READ,
        S_DONE
    } state_t;

    state_t         state_reg, state_next;
    logic [RW-1:0]  sweep_reg, sweep_next;
    logic           item_reg, item_next;
    logic           start_ok_reg, start_ok_next;
    logic           hit_reg, hit_next;
    logic [DW-1:0]  depth_reg, depth_next;
    logic [CW-1:0]  pc_reg, pc_next;
    logic [RW-1:0]  pr_reg, pr_next;
    logic [7:0]     order_reg, order_next;
    logic [1:0]     k_reg, k_next;
    logic [1:0]     dir_reg, dir_next;
    logic [CW-1:0]  tgt_col_reg, tgt_col_next;
    logic [RW-1:0]  tgt_row_reg, tgt_row_next;
    logic [CW-1:0]  mid_col_reg, mid_col_next;
    logic [RW-1:0]  mid_row_reg, mid_row_next;
    logic [3:0]     mask_reg, mask_next;
    logic           wall_reg, wall_next;
    logic           ignored_reg, ignored_next;

    logic                 g_we, g_re;
    logic [RW-1:0]        g_waddr, g_raddr;
    logic [GRID_COLS-1:0] g_wdata, g_rdata;
    logic                 s_we, s_re;
    logic [SW-1:0]        s_waddr, s_raddr;
    logic [EW-1:0]        s_wdata, s_rdata;

    logic [CBW-1:0] cols_bound;
    logic [RBW-1:0] rows_bound;
    logic [1:0]     dir;
    logic [CX-1:0]  pcx, nb_col, mb_col;
    logic [RX-1:0]  prx, nb_row, mb_row;
    logic           nb_ok, room, last_dir, start_ok, read_hit;
    logic [DW-1:0]  depth_dec;
    state_t         adv_state;

    function automatic logic [GRID_COLS-1:0] col_bit(input logic [CW-1:0] c);
        return {{(GRID_COLS-1){1'b0}}, 1'b1} << c;
    endfunction

    gmc_ram #(.WIDTH(GRID_COLS), .DEPTH(GRID_ROWS)) u_grid (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .re    (g_re),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    gmc_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign cols_bound = (32'(cfg.width_in_use) > 32'(GRID_COLS)) ? CBW'(GRID_COLS)
                                                                 : CBW'(cfg.width_in_use);
    assign rows_bound = (32'(cfg.height_in_use) > 32'(GRID_ROWS)) ? RBW'(GRID_ROWS)
                                                                  : RBW'(cfg.height_in_use);

    assign dir       = order_reg[{~k_reg, 1'b1} -: 2];
    assign pcx       = {1'b0, pc_reg};
    assign prx       = {1'b0, pr_reg};
    assign room      = 32'(depth_reg) < STACK_DEPTH;
    assign last_dir  = (k_reg == 2'd3);
    assign adv_state = last_dir ? S_DONE : S_DIR;
    assign depth_dec = depth_reg - DW'(1);
    assign start_ok  = (32'(cell_col) < 32'(cols_bound)) && (32'(cell_row) < 32'(rows_bound));
    assign read_hit  = (32'(cell_col) < GRID_COLS) && (32'(cell_row) < GRID_ROWS);

    // Underflow on west or north wraps above any bound.
    always_comb
    begin
        nb_col = pcx;
        nb_row = prx;
        mb_col = pcx;
        mb_row = prx;
        unique case (dir)
            gmc_pkg::DIR_EAST:
            begin
                nb_col = pcx + CX'(2);
                mb_col = pcx + CX'(1);
            end
            gmc_pkg::DIR_WEST:
            begin
                nb_col = pcx - CX'(2);
                mb_col = pcx - CX'(1);
            end
            gmc_pkg::DIR_SOUTH:
            begin
                nb_row = prx + RX'(2);
                mb_row = prx + RX'(1);
            end
            default:
            begin
                nb_row = prx - RX'(2);
                mb_row = prx - RX'(1);
            end
        endcase
        nb_ok = (32'(nb_col) < 32'(cols_bound)) && (32'(nb_row) < 32'(rows_bound));
    end

    always_comb
    begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        item_next     = item_reg;
        start_ok_next = start_ok_reg;
        hit_next      = hit_reg;
        depth_next    = depth_reg;
        pc_next       = pc_reg;
        pr_next       = pr_reg;
        order_next    = order_reg;
        k_next        = k_reg;
        dir_next      = dir_reg;
        tgt_col_next  = tgt_col_reg;
        tgt_row_next  = tgt_row_reg;
        mid_col_next  = mid_col_reg;
        mid_row_next  = mid_row_reg;
        mask_next     = mask_reg;
        wall_next     = wall_reg;
        ignored_next  = ignored_reg;
        g_we    = 1'b0;
        g_waddr = '0;
        g_wdata = '0;
        g_re    = 1'b0;
        g_raddr = '0;
        s_we    = 1'b0;
        s_waddr = '0;
        s_wdata = '0;
        s_re    = 1'b0;
        s_raddr = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                g_we    = 1'b1;
                g_waddr = sweep_reg;
                g_wdata = '1;
                if (start_ok_reg && (sweep_reg == tgt_row_reg))
                begin
                    g_wdata = ~col_bit(tgt_col_reg);
                end
                sweep_next = sweep_reg + RW'(1);
                if (sweep_reg == RW'(GRID_ROWS - 1))
                begin
                    state_next = item_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pc_next      = '0;
                    pr_next      = '0;
                    mask_next    = '0;
                    wall_next    = 1'b0;
                    ignored_next = 1'b0;
                    unique case (op)
                        gmc_pkg::OP_START:
                        begin
                            item_next     = 1'b1;
                            start_ok_next = start_ok;
                            tgt_col_next  = CW'(cell_col);
                            tgt_row_next  = RW'(cell_row);
                            sweep_next    = '0;
                            depth_next    = start_ok ? DW'(1) : '0;
                            s_we          = start_ok;
                            s_wdata       = {CW'(cell_col), RW'(cell_row)};
                            state_next    = S_CLEAR;
                        end
                        gmc_pkg::OP_STEP:
                        begin
                            order_next = gmc_pkg::order_lookup(order_index);
                            if (depth_reg == '0)
                            begin
                                ignored_next = 1'b1;
                                state_next   = S_DONE;
                            end
                            else
                            begin
                                s_re       = 1'b1;
                                s_raddr    = depth_dec[SW-1:0];
                                depth_next = depth_dec;
                                state_next = S_POP;
                            end
                        end
                        gmc_pkg::OP_READ:
                        begin
                            hit_next     = read_hit;
                            tgt_col_next = CW'(cell_col);
                            g_re         = read_hit;
                            g_raddr      = RW'(cell_row);
                            state_next   = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                pc_next    = s_rdata[EW-1:RW];
                pr_next    = s_rdata[RW-1:0];
                k_next     = 2'd0;
                state_next = S_DIR;
            end
            S_DIR:
            begin
                if (nb_ok && room)
                begin
                    g_re         = 1'b1;
                    g_raddr      = nb_row[RW-1:0];
                    tgt_col_next = nb_col[CW-1:0];
                    tgt_row_next = nb_row[RW-1:0];
                    mid_col_next = mb_col[CW-1:0];
                    mid_row_next = mb_row[RW-1:0];
                    dir_next     = dir;
                    state_next   = S_CHECK;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = adv_state;
                end
            end
            S_CHECK:
            begin
                k_next     = k_reg + 2'd1;
                state_next = adv_state;
                if (g_rdata[tgt_col_reg])
                begin
                    g_we       = 1'b1;
                    g_waddr    = tgt_row_reg;
                    s_we       = 1'b1;
                    s_waddr    = depth_reg[SW-1:0];
                    s_wdata    = {tgt_col_reg, tgt_row_reg};
                    depth_next = depth_reg + DW'(1);
                    mask_next  = mask_reg | (4'b0001 << dir_reg);
                    if ((dir_reg == gmc_pkg::DIR_EAST) || (dir_reg == gmc_pkg::DIR_WEST))
                    begin
                        g_wdata = g_rdata & ~col_bit(tgt_col_reg) & ~col_bit(mid_col_reg);
                    end
                    else
                    begin
                        g_wdata    = g_rdata & ~col_bit(tgt_col_reg);
                        g_re       = 1'b1;
                        g_raddr    = mid_row_reg;
                        k_next     = k_reg;
                        state_next = S_MID;
                    end
                end
            end
            S_MID:
            begin
                g_we       = 1'b1;
                g_waddr    = mid_row_reg;
                g_wdata    = g_rdata & ~col_bit(mid_col_reg);
                k_next     = k_reg + 2'd1;
                state_next = adv_state;
            end
            S_READ:
            begin
                wall_next  = hit_reg ? g_rdata[tgt_col_reg] : 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            sweep_reg    <= '0;
            item_reg     <= 1'b0;
            start_ok_reg <= 1'b0;
            hit_reg      <= 1'b0;
            depth_reg    <= '0;
            pc_reg       <= '0;
            pr_reg       <= '0;
            order_reg    <= '0;
            k_reg        <= '0;
            dir_reg      <= '0;
            tgt_col_reg  <= '0;
            tgt_row_reg  <= '0;
            mid_col_reg  <= '0;
            mid_row_reg  <= '0;
            mask_reg     <= '0;
            wall_reg     <= 1'b0;
            ignored_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            item_reg     <= item_next;
            start_ok_reg <= start_ok_next;
            hit_reg      <= hit_next;
            depth_reg    <= depth_next;
            pc_reg       <= pc_next;
            pr_reg       <= pr_next;
            order_reg    <= order_next;
            k_reg        <= k_next;
            dir_reg      <= dir_next;
            tgt_col_reg  <= tgt_col_next;
            tgt_row_reg  <= tgt_row_next;
            mid_col_reg  <= mid_col_next;
            mid_row_reg  <= mid_row_next;
            mask_reg     <= mask_next;
            wall_reg     <= wall_next;
            ignored_reg  <= ignored_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    assign res.popped_col   = 6'(pc_reg);
    assign res.popped_row   = 5'(pr_reg);
    assign res.carved_mask  = mask_reg;
    assign res.wall_bit     = wall_reg;
    assign res.stack_empty  = (depth_reg == '0);
    assign res.step_ignored = ignored_reg;

`ifndef SYNTH
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(depth_reg) <= STACK_DEPTH)
        else $error("stack depth beyond capacity");

    a_grid_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        !(g_we && g_re && (g_waddr == g_raddr)))
        else $error("grid row read and written in the same cycle");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (s_we && (state_reg == S_CHECK)) |-> room)
        else $error("push onto a full stack");

    a_carve_grows_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && mask_next != mask_reg) |=> (depth_reg == $past(depth_reg) + DW'(1)))
        else $error("direction carved without a push");
`endif

endmodule

// File: rtl/grid_maze_carver.sv
// ----------------------------------------------------------------------------
// grid_maze_carver
// Depth-first maze carver on a wall-bit grid with a cell stack.
// ----------------------------------------------------------------------------
// Each word in gives one word out. The grid is held one row per memory word,
// so a start word sweeps the whole grid to walls one row a cycle; the same
// sweep runs after reset while in_stall is high. A carve step pops a cell
// and then takes each direction in turn: it skips one whose target is out
// of bounds or finds the stack full, else reads the target row and carves
// an open target; when south or north is carved, the in-between row needs
// its own read-modify-write through the single grid read port. A read word
// reads one grid row; a step on an empty stack and a no-op go straight to
// the result. Results sit in an output register, so the next word is taken
// while a result waits.
// ----------------------------------------------------------------------------
module grid_maze_carver #(
    parameter int GRID_COLS   = 64,
    parameter int GRID_ROWS   = 32,
    parameter int STACK_DEPTH = 512
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gmc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       op,
    input  logic [5:0]                       cell_col,
    input  logic [4:0]                       cell_row,
    input  logic [4:0]                       order_index,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [5:0]                       popped_col,
    output logic [4:0]                       popped_row,
    output logic [3:0]                       carved_mask,
    output logic                             wall_bit,
    output logic                             stack_empty,
    output logic                             step_ignored
);

    gmc_pkg::gmc_cfg_t    cfg_reg, cfg_next;
    gmc_pkg::gmc_result_t res;
    gmc_pkg::gmc_result_t out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 res_valid, res_take;

    gmc_engine #(
        .GRID_COLS   (GRID_COLS),
        .GRID_ROWS   (GRID_ROWS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .cell_col    (cell_col),
        .cell_row    (cell_row),
        .order_index (order_index),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res)
    );

    assign cfg_ready = 1'b1;
    assign res_take  = !out_valid_reg || !out_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                gmc_pkg::CFG_WIDTH_IDX:  cfg_next.width_in_use  = cfg_data[6:0];
                gmc_pkg::CFG_HEIGHT_IDX: cfg_next.height_in_use = cfg_data[5:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (res_valid && res_take)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_in_use  <= gmc_pkg::WIDTH_RESET;
            cfg_reg.height_in_use <= gmc_pkg::HEIGHT_RESET;
            out_reg               <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_col   = out_reg.popped_col;
    assign popped_row   = out_reg.popped_row;
    assign carved_mask  = out_reg.carved_mask;
    assign wall_bit     = out_reg.wall_bit;
    assign stack_empty  = out_reg.stack_empty;
    assign step_ignored = out_reg.step_ignored;

endmodule

// File: test/grid_maze_carver_tb.sv
// ----------------------------------------------------------------------------
// grid_maze_carver_tb
// Self-checking regression for the depth-first maze carver. A scoreboard
// class keeps its own wall grid and cell stack, predicts every result word
// and checks the block's output in order. Stimulus is a short directed run
// followed by carve runs at many grid sizes, with random gaps and stalls and
// one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module grid_maze_carver_tb;

    localparam int GRID_COLS   = 64;
    localparam int GRID_ROWS   = 32;
    localparam int STACK_WORDS = 512;
    localparam int WORD_TARGET = 1050;
    localparam int CYCLE_LIMIT = 400000;

    class maze_scoreboard;
        bit [GRID_COLS-1:0]   wall_rows [GRID_ROWS];
        logic [5:0]           stk_col [STACK_WORDS];
        logic [4:0]           stk_row [STACK_WORDS];
        int                   depth;
        logic [6:0]           cols_cfg;
        logic [5:0]           rows_cfg;
        logic [1:0]           dir_seq [4];
        gmc_pkg::gmc_result_t pending_results [$];
        int                   mismatches;

        function new();
            foreach (wall_rows[r])
                wall_rows[r] = '1;
            depth      = 0;
            cols_cfg   = gmc_pkg::WIDTH_RESET;
            rows_cfg   = gmc_pkg::HEIGHT_RESET;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void write_reg(logic [gmc_pkg::CFG_IDX_W-1:0] idx,
                                logic [gmc_pkg::CFG_DATA_W-1:0] data);
            if (idx == gmc_pkg::CFG_WIDTH_IDX)
                cols_cfg = data;
            else if (idx == gmc_pkg::CFG_HEIGHT_IDX)
                rows_cfg = data[5:0];
        endfunction

        // lexicographic permutation of east, west, south, north
        function void pick_order(logic [4:0] oidx);
            int         radix [4];
            int         rem;
            int         sel;
            logic [1:0] pool [$];
            radix = '{6, 2, 1, 1};
            pool  = '{gmc_pkg::DIR_EAST, gmc_pkg::DIR_WEST,
                      gmc_pkg::DIR_SOUTH, gmc_pkg::DIR_NORTH};
            rem   = oidx % 24;
            for (int k = 0; k < 4; k++)
            begin
                sel        = rem / radix[k];
                rem        = rem % radix[k];
                dir_seq[k] = pool[sel];
                pool.delete(sel);
            end
        endfunction

        function void note_word(logic [1:0] op, logic [5:0] col, logic [4:0] row,
                                logic [4:0] oidx);
            gmc_pkg::gmc_result_t res;
            int          cb;
            int          rb;
            int          pc;
            int          pr;
            int          dx;
            int          dy;
            int          nx;
            int          ny;
            res = '0;
            cb  = (cols_cfg > GRID_COLS) ? GRID_COLS : cols_cfg;
            rb  = (rows_cfg > GRID_ROWS) ? GRID_ROWS : rows_cfg;
            case (op)
                gmc_pkg::OP_START:
                begin
                    foreach (wall_rows[r])
                        wall_rows[r] = '1;
                    depth = 0;
                    if (col < cb && row < rb)
                    begin
                        wall_rows[row][col] = 1'b0;
                        stk_col[0] = col;
                        stk_row[0] = row;
                        depth = 1;
                    end
                end
                gmc_pkg::OP_STEP:
                begin
                    if (depth == 0)
                        res.step_ignored = 1'b1;
                    else
                    begin
                        depth = depth - 1;
                        res.popped_col = stk_col[depth];
                        res.popped_row = stk_row[depth];
                        pc = int'(res.popped_col);
                        pr = int'(res.popped_row);
                        pick_order(oidx);
                        for (int k = 0; k < 4; k++)
                        begin
                            case (dir_seq[k])
                                gmc_pkg::DIR_EAST:  begin dx =  1; dy =  0; end
                                gmc_pkg::DIR_WEST:  begin dx = -1; dy =  0; end
                                gmc_pkg::DIR_SOUTH: begin dx =  0; dy =  1; end
                                default:            begin dx =  0; dy = -1; end
                            endcase
                            nx = pc + 2 * dx;
                            ny = pr + 2 * dy;
                            if (nx >= 0 && nx < cb && ny >= 0 && ny < rb && depth < STACK_WORDS)
                            begin
                                if (wall_rows[ny][nx])
                                begin
                                    wall_rows[ny][nx]           = 1'b0;
                                    wall_rows[pr + dy][pc + dx] = 1'b0;
                                    stk_col[depth] = nx[5:0];
                                    stk_row[depth] = ny[4:0];
                                    depth = depth + 1;
                                    res.carved_mask[dir_seq[k]] = 1'b1;
                                end
                            end
                        end
                    end
                end
                gmc_pkg::OP_READ:
                    res.wall_bit = wall_rows[row][col];
                default: ;
            endcase
            res.stack_empty = (depth == 0);
            pending_results.push_back(res);
        endfunction

        function void check_word(gmc_pkg::gmc_result_t got);
            gmc_pkg::gmc_result_t want;
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result word: %p", got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.popped_col !== want.popped_col || got.popped_row !== want.popped_row ||
                got.carved_mask !== want.carved_mask || got.wall_bit !== want.wall_bit ||
                got.stack_empty !== want.stack_empty || got.step_ignored !== want.step_ignored)
            begin
                if (mismatches < 10)
                    $display("result mismatch: expected %p, got %p", want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n       = 1'b0;
    logic                           cfg_valid   = 1'b0;
    logic                           cfg_ready;
    logic [gmc_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [gmc_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
    logic                           in_valid    = 1'b0;
    logic                           in_stall;
    logic [1:0]                     op          = gmc_pkg::OP_NOP;
    logic [5:0]                     cell_col    = '0;
    logic [4:0]                     cell_row    = '0;
    logic [4:0]                     order_index = '0;
    logic                           out_valid;
    logic                           out_stall   = 1'b0;
    logic [5:0]                     popped_col;
    logic [4:0]                     popped_row;
    logic [3:0]                     carved_mask;
    logic                           wall_bit;
    logic                           stack_empty;
    logic                           step_ignored;

    maze_scoreboard board       = new();
    int unsigned    sent_words  = 0;
    int unsigned    cycle_count = 0;
    int unsigned    hold_left   = 0;
    bit             hold_done   = 1'b0;

    grid_maze_carver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .cell_col     (cell_col),
        .cell_row     (cell_row),
        .order_index  (order_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_col   (popped_col),
        .popped_row   (popped_row),
        .carved_mask  (carved_mask),
        .wall_bit     (wall_bit),
        .stack_empty  (stack_empty),
        .step_ignored (step_ignored)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function bit calm_now();
        return sent_words >= 250 && sent_words < 450;
    endfunction

    function logic [5:0] rnd_col();
        return 6'($urandom_range(63));
    endfunction

    function logic [4:0] rnd_row();
        return 5'($urandom_range(31));
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("grid_maze_carver regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_word('{popped_col, popped_row, carved_mask, wall_bit,
                               stack_empty, step_ignored});
    end

    // output side: random stalls plus one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && sent_words >= 520)
        begin
            hold_done <= 1'b1;
            hold_left <= 300;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm_now() && $urandom_range(99) < 6;
    end

    task automatic send_word(logic [1:0] w_op, logic [5:0] w_col, logic [4:0] w_row,
                             logic [4:0] w_oidx);
        @(negedge clk);
        while (!calm_now() && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= w_op;
        cell_col    <= w_col;
        cell_row    <= w_row;
        order_index <= w_oidx;
        do
            @(posedge clk);
        while (in_stall);
        board.note_word(w_op, w_col, w_row, w_oidx);
        sent_words++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [gmc_pkg::CFG_IDX_W-1:0] idx,
                             logic [gmc_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one carve run: a start word, then mostly steps until the stack runs dry
    task automatic carve_run(int cb, int rb, int cap);
        int n;
        int pick;
        logic [5:0] c;
        logic [4:0] r;
        n = 0;
        c = 6'((cb > 0 && $urandom_range(9) != 0) ? $urandom_range(cb - 1)
                                                  : $urandom_range(63));
        r = 5'((rb > 0 && $urandom_range(9) != 0) ? $urandom_range(rb - 1)
                                                  : $urandom_range(31));
        send_word(gmc_pkg::OP_START, c, r, rnd_row());
        while (board.depth != 0 && n < cap && sent_words < WORD_TARGET)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_word(gmc_pkg::OP_READ, rnd_col(), rnd_row(), rnd_row());
            else if (pick < 10)
                send_word(gmc_pkg::OP_NOP, rnd_col(), rnd_row(), rnd_row());
            else if (pick < 11 && cb > 0 && rb > 0)
                send_word(gmc_pkg::OP_START, 6'($urandom_range(cb - 1)),
                          5'($urandom_range(rb - 1)), rnd_row());
            else
                send_word(gmc_pkg::OP_STEP, rnd_col(), rnd_row(), rnd_row());
            n++;
        end
        if ($urandom_range(1) == 0)
            send_word(gmc_pkg::OP_STEP, rnd_col(), rnd_row(), rnd_row());
        send_word(gmc_pkg::OP_READ, rnd_col(), rnd_row(), rnd_row());
    endtask

    initial
    begin
        int phase;
        int w;
        int h;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at reset sizes, 40 by 30
        send_word(gmc_pkg::OP_STEP,  6'd0,  5'd0,  5'd0);
        send_word(gmc_pkg::OP_READ,  6'd0,  5'd0,  5'd0);
        send_word(gmc_pkg::OP_READ,  6'd63, 5'd31, 5'd31);
        send_word(gmc_pkg::OP_NOP,   6'd63, 5'd31, 5'd31);
        send_word(gmc_pkg::OP_START, 6'd45, 5'd5,  5'd0);
        send_word(gmc_pkg::OP_STEP,  6'd0,  5'd0,  5'd0);
        send_word(gmc_pkg::OP_START, 6'd39, 5'd29, 5'd0);
        send_word(gmc_pkg::OP_STEP,  6'd0,  5'd0,  5'd0);
        send_word(gmc_pkg::OP_STEP,  6'd0,  5'd0,  5'd23);
        send_word(gmc_pkg::OP_STEP,  6'd0,  5'd0,  5'd24);
        send_word(gmc_pkg::OP_STEP,  6'd0,  5'd0,  5'd31);
        send_word(gmc_pkg::OP_READ,  6'd39, 5'd29, 5'd0);
        send_word(gmc_pkg::OP_READ,  6'd38, 5'd29, 5'd0);
        send_word(gmc_pkg::OP_START, 6'd0,  5'd0,  5'd0);
        send_word(gmc_pkg::OP_STEP,  6'd0,  5'd0,  5'd5);
        send_word(gmc_pkg::OP_STEP,  6'd0,  5'd0,  5'd10);
        send_word(gmc_pkg::OP_STEP,  6'd0,  5'd0,  5'd15);
        send_word(gmc_pkg::OP_STEP,  6'd0,  5'd0,  5'd17);
        send_word(gmc_pkg::OP_STEP,  6'd0,  5'd0,  5'd20);
        send_word(gmc_pkg::OP_READ,  6'd1,  5'd0,  5'd0);
        send_word(gmc_pkg::OP_READ,  6'd2,  5'd0,  5'd0);
        send_word(gmc_pkg::OP_START, 6'd20, 5'd31, 5'd0);
        send_word(gmc_pkg::OP_STEP,  6'd0,  5'd0,  5'd0);

        phase = 0;
        while (sent_words < WORD_TARGET)
        begin
            drain_results();
            case (phase)
                0: begin w = 127; h = 63; end
                1: begin w = 0;   h = 0;  end
                2: begin w = 1;   h = 1;  end
                3: begin w = 64;  h = 32; end
                4: begin w = 65;  h = 33; end
                5: begin w = 3;   h = 0;  end
                default:
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        w = $urandom_range(127);
                        h = $urandom_range(63);
                    end
                    else
                    begin
                        w = $urandom_range(1, 20);
                        h = $urandom_range(1, 16);
                    end
                end
            endcase
            write_reg(gmc_pkg::CFG_WIDTH_IDX, 7'(w));
            write_reg(gmc_pkg::CFG_HEIGHT_IDX, 7'(h));
            carve_run((w > GRID_COLS) ? GRID_COLS : w, (h > GRID_ROWS) ? GRID_ROWS : h,
                      (phase == 0) ? 4000 : 150);
            phase++;
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("grid_maze_carver regression: pass");
        else
            $display("grid_maze_carver regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/gmc_pkg.sv
rtl/gmc_ram.sv
rtl/gmc_engine.sv
rtl/grid_maze_carver.sv
test/grid_maze_carver_tb.sv
